@@ hdl/assert_macros.svh @@
// assertion macros for clocked checks under synchronous active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define CHK_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// same-cycle implication
`define CHK_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cpwt_pkg.sv @@
// constants and types for the code page write tracker
package cpwt_pkg;

    localparam logic [31:0] RAM_BYTES  = 32'd131072;
    localparam int          PAGE_SHIFT = 8;

    localparam int FUNC_W    = 2;
    localparam int OFF_W     = 17;
    localparam int LEN_W     = 16;
    localparam int SPAN_W    = OFF_W + 1;
    localparam int TOT_W     = 32;
    localparam int DIRTY_W   = 10;
    localparam int RETRANS_W = 25;
    localparam int CNT_W     = 16;

    localparam logic [CNT_W-1:0] BLOCK_SAT = 16'hFFFF;

    localparam logic [31:0] NUM_PAGES = RAM_BYTES >> PAGE_SHIFT;
    localparam int          PAGE_W    = $clog2(NUM_PAGES);

    // start-seen bitmap is stored as rows of 2^ROW_SH bits
    localparam int          ROW_SH    = 5;
    localparam int          ROW_BITS  = 1 << ROW_SH;
    localparam logic [31:0] SEEN_ROWS = RAM_BYTES >> ROW_SH;
    localparam int          SEEN_AW   = $clog2(SEEN_ROWS);

    localparam logic [31:0] CLR_ROWS = (SEEN_ROWS > NUM_PAGES) ? SEEN_ROWS : NUM_PAGES;
    localparam int          CLR_W    = $clog2(CLR_ROWS);

    typedef enum logic [FUNC_W-1:0] {
        F_BLOCK = 2'd0,
        F_WRITE = 2'd1,
        F_FRAME = 2'd2,
        F_NONE  = 2'd3
    } t_func;

    typedef struct packed {
        logic             code;
        logic [CNT_W-1:0] cnt;
    } t_page;

endpackage

@@ hdl/code_page_write_tracker_unit.sv @@
// code page write tracker: page code map, per-frame dirty tracking and statistics
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-----------------------------------
//  in       | to block  | i_in_valid / o_in_stall    | i_func, i_offset, i_length
//  out      | from block| o_out_valid / i_out_stall  | o_code_hit .. o_retrans_peak
//  cfg      | to block  | i_cfg_valid / o_cfg_ready  | i_cfg_data (counting_enable)
//
// write request: setup, then the page loop over the pages covered; block start request:
// setup, a start-bitmap check, then the page loop if the start is new; the loop does one
// read-modify-write per cycle, of the page store for block starts and of dirty marks for
// writes; frame end while enabled: setup, then a sweep clearing one dirty mark per cycle;
// other requests: setup, then the result; after reset a clearing pass wipes the bitmap,
// page and dirty stores, input stalled; a finished result waits in the output register while the next request is taken
`include "assert_macros.svh"

module code_page_write_tracker_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [cpwt_pkg::FUNC_W-1:0]       i_func,
    input  logic [cpwt_pkg::OFF_W-1:0]        i_offset,
    input  logic [cpwt_pkg::LEN_W-1:0]        i_length,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_code_hit,
    output logic [cpwt_pkg::TOT_W-1:0]        o_frame_count,
    output logic [cpwt_pkg::TOT_W-1:0]        o_block_starts,
    output logic [cpwt_pkg::TOT_W-1:0]        o_writes_total,
    output logic [cpwt_pkg::TOT_W-1:0]        o_writes_on_code,
    output logic [cpwt_pkg::TOT_W-1:0]        o_bytes_written,
    output logic [cpwt_pkg::DIRTY_W-1:0]      o_dirty_pages_now,
    output logic [cpwt_pkg::RETRANS_W-1:0]    o_retrans_now,
    output logic [cpwt_pkg::TOT_W-1:0]        o_dirty_pages_sum,
    output logic [cpwt_pkg::TOT_W-1:0]        o_retrans_sum,
    output logic [cpwt_pkg::DIRTY_W-1:0]      o_dirty_pages_peak,
    output logic [cpwt_pkg::RETRANS_W-1:0]    o_retrans_peak
);
    import cpwt_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_SETUP   = 7'b0000100,
        S_SEEN_WR = 7'b0001000,
        S_PWR     = 7'b0010000,
        S_FCLR    = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

    t_state                 r_state;
    logic [CLR_W-1:0]       r_clr;
    logic                   r_enable;
    logic                   r_out_valid;
    logic                   r_touched;

    logic [FUNC_W-1:0]      r_func;
    logic [OFF_W-1:0]       r_offset;
    logic [LEN_W-1:0]       r_length;
    logic [PAGE_W-1:0]      r_first;
    logic [PAGE_W-1:0]      r_last;
    logic [PAGE_W-1:0]      r_page;

    logic [TOT_W-1:0]       r_frame_total;
    logic [TOT_W-1:0]       r_start_total;
    logic [TOT_W-1:0]       r_write_total;
    logic [TOT_W-1:0]       r_code_write_total;
    logic [TOT_W-1:0]       r_byte_total;
    logic [DIRTY_W-1:0]     r_frame_dirty;
    logic [RETRANS_W-1:0]   r_frame_retrans;
    logic [TOT_W-1:0]       r_dirty_sum;
    logic [TOT_W-1:0]       r_retrans_sum;
    logic [DIRTY_W-1:0]     r_dirty_peak;
    logic [RETRANS_W-1:0]   r_retrans_peak;

    logic                   r_out_touched;
    logic [TOT_W-1:0]       r_out_frame_count;
    logic [TOT_W-1:0]       r_out_block_starts;
    logic [TOT_W-1:0]       r_out_writes_total;
    logic [TOT_W-1:0]       r_out_writes_on_code;
    logic [TOT_W-1:0]       r_out_bytes_written;
    logic [DIRTY_W-1:0]     r_out_dirty_now;
    logic [RETRANS_W-1:0]   r_out_retrans_now;
    logic [TOT_W-1:0]       r_out_dirty_sum;
    logic [TOT_W-1:0]       r_out_retrans_sum;
    logic [DIRTY_W-1:0]     r_out_dirty_peak;
    logic [RETRANS_W-1:0]   r_out_retrans_peak;

    // stores
    logic [ROW_BITS-1:0]    seen_mem [SEEN_ROWS];
    t_page                  page_mem [NUM_PAGES];
    logic                   dirty_mem [NUM_PAGES];

    logic [ROW_BITS-1:0]    r_seen_q;
    t_page                  r_pg_q;
    logic                   r_dm_q;

    logic                   seen_we;
    logic [SEEN_AW-1:0]     seen_waddr;
    logic [ROW_BITS-1:0]    seen_wdata;
    logic                   pg_we;
    logic [PAGE_W-1:0]      pg_waddr;
    t_page                  pg_wdata;
    logic                   dm_we;
    logic [PAGE_W-1:0]      dm_waddr;
    logic                   dm_wdata;
    logic [PAGE_W-1:0]      pg_raddr;

    t_func                  func;
    logic                   in_ram;
    logic [LEN_W-1:0]       len_eff;
    logic [SPAN_W-1:0]      span;
    logic [31:0]            last_raw;
    logic [PAGE_W-1:0]      first_pg;
    logic [PAGE_W-1:0]      last_pg;
    logic [SEEN_AW-1:0]     seen_row;
    logic [ROW_SH-1:0]      seen_bit;
    logic                   seen_hit;
    logic [CNT_W-1:0]       cnt_next;
    logic                   pg_last;
    logic                   pg_dirty_new;
    logic                   out_free;

    assign func     = t_func'(r_func);
    assign in_ram   = 32'(r_offset) < RAM_BYTES;
    assign len_eff  = (r_length == '0) ? LEN_W'(1) : r_length;
    assign span     = SPAN_W'(r_offset) + SPAN_W'(len_eff) - SPAN_W'(1);
    assign last_raw = 32'(span >> PAGE_SHIFT);
    assign last_pg  = (last_raw >= NUM_PAGES) ? PAGE_W'(NUM_PAGES - 32'd1)
                                              : PAGE_W'(last_raw);
    assign first_pg = PAGE_W'(r_offset >> PAGE_SHIFT);
    assign seen_row = SEEN_AW'(r_offset >> ROW_SH);
    assign seen_bit = r_offset[ROW_SH-1:0];
    assign seen_hit = r_seen_q[seen_bit];
    assign pg_last  = (r_page == r_last);
    assign cnt_next = ((r_page == r_first) && (r_pg_q.cnt != BLOCK_SAT))
                    ? r_pg_q.cnt + CNT_W'(1) : r_pg_q.cnt;
    assign pg_dirty_new = (func == F_WRITE) && r_pg_q.code && !r_dm_q;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    assign o_code_hit         = r_out_touched;
    assign o_frame_count      = r_out_frame_count;
    assign o_block_starts     = r_out_block_starts;
    assign o_writes_total     = r_out_writes_total;
    assign o_writes_on_code   = r_out_writes_on_code;
    assign o_bytes_written    = r_out_bytes_written;
    assign o_dirty_pages_now  = r_out_dirty_now;
    assign o_retrans_now      = r_out_retrans_now;
    assign o_dirty_pages_sum  = r_out_dirty_sum;
    assign o_retrans_sum      = r_out_retrans_sum;
    assign o_dirty_pages_peak = r_out_dirty_peak;
    assign o_retrans_peak     = r_out_retrans_peak;

    // store port control
    always_comb begin
        seen_we    = 1'b0;
        seen_waddr = seen_row;
        seen_wdata = r_seen_q | (ROW_BITS'(1) << seen_bit);
        pg_we      = 1'b0;
        pg_waddr   = r_page;
        pg_wdata   = '{code: 1'b1, cnt: cnt_next};
        dm_we      = 1'b0;
        dm_waddr   = r_page;
        dm_wdata   = 1'b1;
        pg_raddr   = r_page + PAGE_W'(1);
        unique case (r_state)
            S_CLEAR: begin
                seen_we    = 32'(r_clr) < SEEN_ROWS;
                seen_waddr = r_clr[SEEN_AW-1:0];
                seen_wdata = '0;
                pg_we      = 32'(r_clr) < NUM_PAGES;
                pg_waddr   = r_clr[PAGE_W-1:0];
                pg_wdata   = '0;
                dm_we      = 32'(r_clr) < NUM_PAGES;
                dm_waddr   = r_clr[PAGE_W-1:0];
                dm_wdata   = 1'b0;
            end
            S_SETUP: begin
                pg_raddr = first_pg;
            end
            S_SEEN_WR: begin
                seen_we  = !seen_hit;
                pg_raddr = r_first;
            end
            S_PWR: begin
                pg_we = (func == F_BLOCK);
                dm_we = pg_dirty_new;
            end
            S_FCLR: begin
                dm_we    = 1'b1;
                dm_waddr = r_clr[PAGE_W-1:0];
                dm_wdata = 1'b0;
            end
            S_IDLE, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (seen_we) begin
            seen_mem[seen_waddr] <= seen_wdata;
        end
        r_seen_q <= seen_mem[seen_row];
    end

    always_ff @(posedge i_clk) begin
        if (pg_we) begin
            page_mem[pg_waddr] <= pg_wdata;
        end
        r_pg_q <= page_mem[pg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            dirty_mem[dm_waddr] <= dm_wdata;
        end
        r_dm_q <= dirty_mem[pg_raddr];
    end

    // sequencer and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_CLEAR;
            r_clr              <= '0;
            r_enable           <= 1'b0;
            r_out_valid        <= 1'b0;
            r_touched          <= 1'b0;
            r_frame_total      <= '0;
            r_start_total      <= '0;
            r_write_total      <= '0;
            r_code_write_total <= '0;
            r_byte_total       <= '0;
            r_frame_dirty      <= '0;
            r_frame_retrans    <= '0;
            r_dirty_sum        <= '0;
            r_retrans_sum      <= '0;
            r_dirty_peak       <= '0;
            r_retrans_peak     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CLR_W'(1);
                    if (r_clr == CLR_W'(CLR_ROWS - 32'd1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_touched <= 1'b0;
                        r_state   <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_clr <= '0;
                    unique case (func)
                        F_BLOCK: begin
                            r_state <= (r_enable && in_ram) ? S_SEEN_WR : S_DONE;
                        end
                        F_WRITE: begin
                            r_write_total <= r_write_total + TOT_W'(1);
                            r_byte_total  <= r_byte_total + TOT_W'(r_length);
                            r_state       <= in_ram ? S_PWR : S_DONE;
                        end
                        F_FRAME: begin
                            if (r_enable) begin
                                r_frame_total   <= r_frame_total + TOT_W'(1);
                                r_dirty_sum     <= r_dirty_sum + TOT_W'(r_frame_dirty);
                                r_retrans_sum   <= r_retrans_sum + TOT_W'(r_frame_retrans);
                                if (r_frame_dirty > r_dirty_peak) begin
                                    r_dirty_peak <= r_frame_dirty;
                                end
                                if (r_frame_retrans > r_retrans_peak) begin
                                    r_retrans_peak <= r_frame_retrans;
                                end
                                r_frame_dirty   <= '0;
                                r_frame_retrans <= '0;
                                r_state         <= S_FCLR;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        F_NONE: begin
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_SEEN_WR: begin
                    if (seen_hit) begin
                        r_state <= S_DONE;
                    end else begin
                        r_start_total <= r_start_total + TOT_W'(1);
                        r_state       <= S_PWR;
                    end
                end
                S_PWR: begin
                    if ((func == F_WRITE) && r_pg_q.code) begin
                        r_touched <= 1'b1;
                    end
                    if (pg_dirty_new) begin
                        r_frame_dirty   <= r_frame_dirty + DIRTY_W'(1);
                        r_frame_retrans <= r_frame_retrans + RETRANS_W'(r_pg_q.cnt);
                    end
                    if (pg_last) begin
                        if ((func == F_WRITE) && (r_touched || r_pg_q.code)) begin
                            r_code_write_total <= r_code_write_total + TOT_W'(1);
                        end
                        r_state <= S_DONE;
                    end
                end
                S_FCLR: begin
                    r_clr <= r_clr + CLR_W'(1);
                    if (r_clr[PAGE_W-1:0] == PAGE_W'(NUM_PAGES - 32'd1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // request capture, page walk and result register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_func   <= i_func;
            r_offset <= i_offset;
            r_length <= i_length;
        end
        if (r_state == S_SETUP) begin
            r_first <= first_pg;
            r_last  <= last_pg;
            r_page  <= first_pg;
        end
        if ((r_state == S_PWR) && !pg_last) begin
            r_page <= r_page + PAGE_W'(1);
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_touched        <= r_touched;
            r_out_frame_count    <= r_frame_total;
            r_out_block_starts   <= r_start_total;
            r_out_writes_total   <= r_write_total;
            r_out_writes_on_code <= r_code_write_total;
            r_out_bytes_written  <= r_byte_total;
            r_out_dirty_now      <= r_frame_dirty;
            r_out_retrans_now    <= r_frame_retrans;
            r_out_dirty_sum      <= r_dirty_sum;
            r_out_retrans_sum    <= r_retrans_sum;
            r_out_dirty_peak     <= r_dirty_peak;
            r_out_retrans_peak   <= r_retrans_peak;
        end
    end

    `CHK_IMPL(a_page_in_span, r_state == S_PWR, r_page <= r_last, "page walk past span")
    `CHK_ALWAYS(a_dirty_bound, 32'(r_frame_dirty) <= NUM_PAGES, "dirty count above page count")
    `CHK_IMPL(a_sweep_zero, r_state == S_FCLR, {r_frame_dirty, r_frame_retrans} == '0, "frame kept")
    `CHK_NEXT(a_done_loads, (r_state == S_DONE) && out_free, r_out_valid, "result not loaded")
    `CHK_IMPL(a_touch_write, r_touched, func == F_WRITE, "touched flag on non-write")

endmodule

@@ test/cpwt_stats_checker.sv @@
// checker that predicts the code page tracker statistics and compares every result
module cpwt_stats_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [cpwt_pkg::FUNC_W-1:0]    i_func,
    input  logic [cpwt_pkg::OFF_W-1:0]     i_offset,
    input  logic [cpwt_pkg::LEN_W-1:0]     i_length,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic                           i_cfg_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_code_hit,
    input  logic [cpwt_pkg::TOT_W-1:0]     i_frame_count,
    input  logic [cpwt_pkg::TOT_W-1:0]     i_block_starts,
    input  logic [cpwt_pkg::TOT_W-1:0]     i_writes_total,
    input  logic [cpwt_pkg::TOT_W-1:0]     i_writes_on_code,
    input  logic [cpwt_pkg::TOT_W-1:0]     i_bytes_written,
    input  logic [cpwt_pkg::DIRTY_W-1:0]   i_dirty_pages_now,
    input  logic [cpwt_pkg::RETRANS_W-1:0] i_retrans_now,
    input  logic [cpwt_pkg::TOT_W-1:0]     i_dirty_pages_sum,
    input  logic [cpwt_pkg::TOT_W-1:0]     i_retrans_sum,
    input  logic [cpwt_pkg::DIRTY_W-1:0]   i_dirty_pages_peak,
    input  logic [cpwt_pkg::RETRANS_W-1:0] i_retrans_peak,
    output int                             o_mismatches,
    output int                             o_owed
);
    import cpwt_pkg::*;

    typedef struct packed {
        logic                 touched;
        logic [TOT_W-1:0]     frames;
        logic [TOT_W-1:0]     starts;
        logic [TOT_W-1:0]     writes;
        logic [TOT_W-1:0]     code_writes;
        logic [TOT_W-1:0]     byte_sum;
        logic [DIRTY_W-1:0]   dirty_now;
        logic [RETRANS_W-1:0] retrans_now;
        logic [TOT_W-1:0]     dirty_sum;
        logic [TOT_W-1:0]     retrans_sum;
        logic [DIRTY_W-1:0]   dirty_peak;
        logic [RETRANS_W-1:0] retrans_peak;
    } t_stats;

    logic             counting_on;
    bit               start_mark  [0:RAM_BYTES-1];
    bit               code_page   [0:NUM_PAGES-1];
    logic [CNT_W-1:0] blk_count   [0:NUM_PAGES-1];
    bit               dirty_mark  [0:NUM_PAGES-1];
    t_stats           tally;
    t_stats           stats_due [$];

    function automatic t_stats next_tracker_stats(input t_func f, input int unsigned off,
                                                  input int unsigned len);
        int unsigned first;
        int unsigned last;
        tally.touched = 1'b0;
        first = off >> PAGE_SHIFT;
        last = (off + ((len == 0) ? 1 : len) - 1) >> PAGE_SHIFT;
        if (last >= NUM_PAGES) last = NUM_PAGES - 1;
        case (f)
            F_BLOCK: begin
                if (counting_on && off < RAM_BYTES && !start_mark[off]) begin
                    start_mark[off] = 1'b1;
                    tally.starts++;
                    for (int unsigned p = first; p <= last; p++) code_page[p] = 1'b1;
                    if (blk_count[first] != BLOCK_SAT) blk_count[first]++;
                end
            end
            F_WRITE: begin
                tally.writes++;
                tally.byte_sum += len;
                if (first < NUM_PAGES) begin
                    for (int unsigned p = first; p <= last; p++) begin
                        if (code_page[p]) begin
                            tally.touched = 1'b1;
                            if (!dirty_mark[p]) begin
                                dirty_mark[p] = 1'b1;
                                tally.dirty_now++;
                                tally.retrans_now += blk_count[p];
                            end
                        end
                    end
                    if (tally.touched) tally.code_writes++;
                end
            end
            F_FRAME: begin
                if (counting_on) begin
                    tally.frames++;
                    tally.dirty_sum += tally.dirty_now;
                    tally.retrans_sum += tally.retrans_now;
                    if (tally.dirty_now > tally.dirty_peak) tally.dirty_peak = tally.dirty_now;
                    if (tally.retrans_now > tally.retrans_peak) begin
                        tally.retrans_peak = tally.retrans_now;
                    end
                    foreach (dirty_mark[p]) dirty_mark[p] = 1'b0;
                    tally.dirty_now = '0;
                    tally.retrans_now = '0;
                end
            end
            default: ;
        endcase
        return tally;
    endfunction

    task automatic check_field(input string name, input logic [TOT_W-1:0] want,
                               input logic [TOT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_stats got;
        t_stats want;
        if (!i_rst_n) begin
            counting_on = 1'b0;
            foreach (start_mark[a]) start_mark[a] = 1'b0;
            foreach (code_page[p]) begin
                code_page[p] = 1'b0;
                blk_count[p] = '0;
                dirty_mark[p] = 1'b0;
            end
            tally = '0;
            stats_due.delete();
            o_mismatches = 0;
            o_owed = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) counting_on = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                got = {i_code_hit, i_frame_count, i_block_starts, i_writes_total,
                       i_writes_on_code, i_bytes_written, i_dirty_pages_now, i_retrans_now,
                       i_dirty_pages_sum, i_retrans_sum, i_dirty_pages_peak, i_retrans_peak};
                if (stats_due.size() == 0) begin
                    $display("%0t: result with none expected, writes_total %0d", $time,
                             got.writes);
                    o_mismatches++;
                end else begin
                    want = stats_due.pop_front();
                    check_field("code_hit", want.touched, got.touched);
                    check_field("frame_count", want.frames, got.frames);
                    check_field("block_starts", want.starts, got.starts);
                    check_field("writes_total", want.writes, got.writes);
                    check_field("writes_on_code", want.code_writes, got.code_writes);
                    check_field("bytes_written", want.byte_sum, got.byte_sum);
                    check_field("dirty_pages_now", want.dirty_now, got.dirty_now);
                    check_field("retrans_now", want.retrans_now, got.retrans_now);
                    check_field("dirty_pages_sum", want.dirty_sum, got.dirty_sum);
                    check_field("retrans_sum", want.retrans_sum, got.retrans_sum);
                    check_field("dirty_pages_peak", want.dirty_peak, got.dirty_peak);
                    check_field("retrans_peak", want.retrans_peak, got.retrans_peak);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                stats_due.push_back(next_tracker_stats(t_func'(i_func), i_offset, i_length));
            end
            o_owed = stats_due.size();
        end
    end

endmodule

@@ test/code_page_write_tracker_unit_test.sv @@
// testbench top for the code page write tracker: stimulus, stalls and verdict
module code_page_write_tracker_unit_test;
    import cpwt_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOT_PAGES   = 16;
    localparam int PHASES      = 6;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [FUNC_W-1:0]    in_func = '0;
    logic [OFF_W-1:0]     in_offset = '0;
    logic [LEN_W-1:0]     in_length = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 code_hit;
    logic [TOT_W-1:0]     frame_count;
    logic [TOT_W-1:0]     block_starts;
    logic [TOT_W-1:0]     writes_total;
    logic [TOT_W-1:0]     writes_on_code;
    logic [TOT_W-1:0]     bytes_written;
    logic [DIRTY_W-1:0]   dirty_pages_now;
    logic [RETRANS_W-1:0] retrans_now;
    logic [TOT_W-1:0]     dirty_pages_sum;
    logic [TOT_W-1:0]     retrans_sum;
    logic [DIRTY_W-1:0]   dirty_pages_peak;
    logic [RETRANS_W-1:0] retrans_peak;

    int mismatches;
    int owed;
    int idle_pct = 0;
    int stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int unsigned hot_page = 0;
    int unsigned last_block_off = 0;

    int   phase_items  [PHASES] = '{180, 180, 180, 120, 180, 200};
    int   phase_idle   [PHASES] = '{0, 70, 0, 28, 28, 0};
    int   phase_stall  [PHASES] = '{0, 0, 70, 28, 28, 0};
    logic phase_enable [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    always #5 clk = ~clk;

    code_page_write_tracker_unit dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_func            (in_func),
        .i_offset          (in_offset),
        .i_length          (in_length),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_data        (cfg_data),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_code_hit        (code_hit),
        .o_frame_count     (frame_count),
        .o_block_starts    (block_starts),
        .o_writes_total    (writes_total),
        .o_writes_on_code  (writes_on_code),
        .o_bytes_written   (bytes_written),
        .o_dirty_pages_now (dirty_pages_now),
        .o_retrans_now     (retrans_now),
        .o_dirty_pages_sum (dirty_pages_sum),
        .o_retrans_sum     (retrans_sum),
        .o_dirty_pages_peak(dirty_pages_peak),
        .o_retrans_peak    (retrans_peak)
    );

    cpwt_stats_checker stats_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_func            (in_func),
        .i_offset          (in_offset),
        .i_length          (in_length),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_data        (cfg_data),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_code_hit        (code_hit),
        .i_frame_count     (frame_count),
        .i_block_starts    (block_starts),
        .i_writes_total    (writes_total),
        .i_writes_on_code  (writes_on_code),
        .i_bytes_written   (bytes_written),
        .i_dirty_pages_now (dirty_pages_now),
        .i_retrans_now     (retrans_now),
        .i_dirty_pages_sum (dirty_pages_sum),
        .i_retrans_sum     (retrans_sum),
        .i_dirty_pages_peak(dirty_pages_peak),
        .i_retrans_peak    (retrans_peak),
        .o_mismatches      (mismatches),
        .o_owed            (owed)
    );

    // receiver side: random stalls plus one long hold-off on request
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_event(input t_func f, input logic [OFF_W-1:0] off,
                              input logic [LEN_W-1:0] len);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_func <= f;
        in_offset <= off;
        in_length <= len;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_random_event();
        int unsigned roll;
        int unsigned off;
        int unsigned len;
        t_func f;
        roll = $urandom_range(99);
        if (roll < 20) f = F_BLOCK;
        else if (roll < 85) f = F_WRITE;
        else if (roll < 95) f = F_FRAME;
        else f = F_NONE;
        roll = $urandom_range(99);
        if (f == F_BLOCK && roll < 15) off = last_block_off;
        else if (roll < 70) off = (hot_page << PAGE_SHIFT)
                                  + $urandom_range((HOT_PAGES << PAGE_SHIFT) - 1);
        else if (roll < 90) off = $urandom_range(RAM_BYTES - 1);
        else off = RAM_BYTES - 1 - $urandom_range(511);
        roll = $urandom_range(99);
        if (roll < 5) len = 0;
        else if (roll < 90) len = (f == F_BLOCK) ? $urandom_range(96, 1) : $urandom_range(4, 1);
        else if (roll < 97) len = $urandom_range(2048, 5);
        else len = $urandom_range(65535);
        if (f == F_BLOCK) last_block_off = off;
        send_event(f, OFF_W'(off), LEN_W'(len));
    endtask

    // lowers the request valid and waits until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (owed != 0) @(negedge clk);
    endtask

    task automatic write_counting_enable(input logic value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // counting disabled: block start and frame end have no effect
        write_counting_enable(1'b0);
        send_event(F_BLOCK, 17'd0, 16'd16);
        send_event(F_FRAME, 17'd0, 16'd0);
        send_event(F_WRITE, 17'd0, 16'd1);
        send_event(F_NONE, 17'h1FFFF, 16'hFFFF);
        drain_results();

        write_counting_enable(1'b1);
        send_event(F_BLOCK, 17'd0, 16'd0);
        send_event(F_BLOCK, 17'd0, 16'd100);
        send_event(F_BLOCK, 17'd1, 16'd300);
        send_event(F_BLOCK, 17'h1FFFF, 16'hFFFF);
        send_event(F_BLOCK, 17'd65536, 16'hFFFF);
        send_event(F_BLOCK, 17'd256, 16'hFFFF);
        send_event(F_WRITE, 17'd0, 16'd0);
        send_event(F_WRITE, 17'd0, 16'd2);
        send_event(F_WRITE, 17'h1FFFF, 16'hFFFF);
        send_event(F_WRITE, 17'd0, 16'hFFFF);
        send_event(F_WRITE, 17'd65536, 16'hFFFF);
        send_event(F_NONE, 17'd0, 16'd0);
        send_event(F_FRAME, 17'd0, 16'd0);
        send_event(F_FRAME, 17'h1FFFF, 16'hFFFF);
        send_event(F_WRITE, 17'd5, 16'd3);
        send_event(F_WRITE, 17'h10000, 16'h8000);
        send_event(F_FRAME, 17'd0, 16'd0);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            write_counting_enable(phase_enable[ph]);
            idle_pct = phase_idle[ph];
            stall_pct <= phase_stall[ph];
            if (ph == 2) hold_req <= 1'b1;
            hot_page = $urandom_range(NUM_PAGES - HOT_PAGES);
            repeat (phase_items[ph]) send_random_event();
        end

        drain_results();
        repeat (600) @(negedge clk);
        if (mismatches == 0 && owed == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
